// ----- design/btrm_pkg.sv -----
// btrm_pkg: shared types and constants for the buffer tag and refcount manager
// no dependencies; used by the interfaces and every module of the block
`timescale 1ns / 1ps
`default_nettype none

package btrm_pkg;

    // default table geometry
    localparam int NUM_BUFFERS_DEF = 32;
    localparam int NUM_BUCKETS_DEF = 13;

    // field widths fixed by the request and response formats
    localparam int DEV_W    = 8;
    localparam int BLK_W    = 32;
    localparam int REFS_W   = 8;
    localparam int SLOT_W   = 5;
    localparam int BUCKET_W = 6;

    localparam logic [REFS_W-1:0] REFS_MAX = '1;

    // request operations
    typedef enum logic [1:0] {
        FUNC_ACQUIRE = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_PIN     = 2'd2,
        FUNC_UNPIN   = 2'd3
    } func_t;

    // response status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOBUF = 2'd1,
        ST_UNDER = 2'd2,
        ST_OVER  = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_SCAN,
        S_COMMIT,
        S_SLOT_RD,
        S_SLOT_UPD
    } state_t;

    // one table entry as held in the entry ram
    typedef struct packed {
        logic [DEV_W-1:0]    device;
        logic [BLK_W-1:0]    block;
        logic [REFS_W-1:0]   refs;
        logic                valid;
        logic [BUCKET_W-1:0] bucket;
    } entry_t;

endpackage

`default_nettype wire

// ----- design/btrm_if.sv -----
// btrm_req_if / btrm_rsp_if: valid/ready channels for requests and responses
// depends on btrm_pkg for field types
`timescale 1ns / 1ps
`default_nettype none

interface btrm_req_if;
    logic                            valid;
    logic                            ready;
    btrm_pkg::func_t                 func;
    logic [btrm_pkg::DEV_W-1:0]      device_number;
    logic [btrm_pkg::BLK_W-1:0]      block_number;
    logic [btrm_pkg::SLOT_W-1:0]     slot_index;

    modport source (
        output valid, func, device_number, block_number, slot_index,
        input  ready
    );
    modport sink (
        input  valid, func, device_number, block_number, slot_index,
        output ready
    );
endinterface

interface btrm_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [btrm_pkg::SLOT_W-1:0]     granted_slot;
    logic                            hit;
    logic                            needs_fill;
    btrm_pkg::status_t               status;

    modport source (
        output valid, granted_slot, hit, needs_fill, status,
        input  ready
    );
    modport sink (
        input  valid, granted_slot, hit, needs_fill, status,
        output ready
    );
endinterface

`default_nettype wire

// ----- design/btrm_mod_unit.sv -----
// btrm_mod_unit: remainder of a block number by the bucket count
// depends on btrm_pkg; reciprocal multiply, then multiply-subtract, each result registered
`timescale 1ns / 1ps
`default_nettype none

module btrm_mod_unit #(
    parameter int NUM_BUCKETS = btrm_pkg::NUM_BUCKETS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [btrm_pkg::BLK_W-1:0]      value,
    output logic                                 done,
    output logic [btrm_pkg::BUCKET_W-1:0]        remainder
);

    localparam int BW    = btrm_pkg::BLK_W;
    localparam int PW    = 2 * BW + 1;
    localparam int SHIFT = BW + $clog2(NUM_BUCKETS);
    // reciprocal rounded up, gives the exact quotient for every dividend
    localparam logic [PW-1:0] POW2    = PW'(1) << SHIFT;
    localparam logic [PW-1:0] DIV_P   = PW'(NUM_BUCKETS);
    localparam logic [PW-1:0] RECIP_P = (POW2 + DIV_P - PW'(1)) / DIV_P;
    localparam logic [BW:0]   RECIP   = RECIP_P[BW:0];
    localparam logic [BW-1:0] DIVISOR = BW'(NUM_BUCKETS);

    logic                            busy_reg;
    logic                            phase_reg;
    logic [BW-1:0]                   val_reg;
    logic [BW-1:0]                   quot_reg;
    logic [btrm_pkg::BUCKET_W-1:0]   rem_reg;
    logic [PW-1:0]                   product;
    logic [PW-1:0]                   product_shr;
    logic [BW-1:0]                   rem_full;

    // quotient by reciprocal, then remainder by multiply-subtract
    always_comb
    begin
        product     = {{(BW+1){1'b0}}, val_reg} * {{BW{1'b0}}, RECIP};
        product_shr = product >> SHIFT;
        rem_full    = val_reg - quot_reg * DIVISOR;
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            phase_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            phase_reg <= 1'b1;
            if (phase_reg)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // dividend, quotient and remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg <= value;
        end
        else if (busy_reg && !phase_reg)
        begin
            quot_reg <= product_shr[BW-1:0];
        end
        else if (busy_reg && phase_reg)
        begin
            rem_reg <= rem_full[btrm_pkg::BUCKET_W-1:0];
        end
    end

    assign done      = !busy_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ----- design/btrm_entry_ram.sv -----
// btrm_entry_ram: single-write, single-read entry table with registered read
// depends on btrm_pkg; per-entry written bits make unwritten entries read as zero
`timescale 1ns / 1ps
`default_nettype none

module btrm_entry_ram #(
    parameter int NUM_BUFFERS = btrm_pkg::NUM_BUFFERS_DEF,
    parameter int AW          = $clog2(NUM_BUFFERS)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output btrm_pkg::entry_t       rd_data,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire btrm_pkg::entry_t  wr_data
);

    btrm_pkg::entry_t            mem [NUM_BUFFERS];
    logic [NUM_BUFFERS-1:0]      written_reg;
    btrm_pkg::entry_t            rd_mem_reg;
    logic                        rd_written_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // written marks, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (wr_en)
        begin
            written_reg[wr_addr] <= 1'b1;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_mem_reg     <= mem[rd_addr];
            rd_written_reg <= written_reg[rd_addr];
        end
    end

    // an entry never written reads as its reset value
    assign rd_data = rd_written_reg ? rd_mem_reg : '0;

endmodule

`default_nettype wire

// ----- design/buffer_tag_refcount_manager.sv -----
// buffer_tag_refcount_manager: top level, sequencer and response register
// depends on btrm_pkg, btrm_if, btrm_mod_unit and btrm_entry_ram
`timescale 1ns / 1ps
`default_nettype none

// Keeps NUM_BUFFERS tagged buffer entries with reference counts. One request
// is worked at a time. An acquire first has the remainder unit compute the
// request's bucket (reciprocal multiply, then multiply-subtract), then makes
// one pass over the entry ram through its single read port, one entry per
// cycle, that finds the first tag match and the nearest free entry together,
// then commits. Release, pin and unpin read the entry, then modify and write
// it. The block is ready again the cycle after commit. The response sits in
// an output register, so a new request is taken while it waits; the block
// only stalls at commit or at the slot update if the previous response is
// still not taken.
// The table is zero after reset with no clearing pass.
module buffer_tag_refcount_manager #(
    parameter int NUM_BUFFERS = btrm_pkg::NUM_BUFFERS_DEF,
    parameter int NUM_BUCKETS = btrm_pkg::NUM_BUCKETS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    btrm_req_if.sink      req,
    btrm_rsp_if.source    rsp
);

    localparam int AW   = $clog2(NUM_BUFFERS);
    localparam int CW   = AW + 1;
    localparam int SW   = btrm_pkg::SLOT_W;
    localparam int BKW  = btrm_pkg::BUCKET_W;
    localparam logic [CW-1:0]     SCAN_END  = CW'(NUM_BUFFERS);
    localparam logic [AW+SW-1:0]  SLOT_LIM  = (AW+SW)'(NUM_BUFFERS);
    localparam logic [BKW:0]      BUCKETS_W = (BKW+1)'(NUM_BUCKETS);
    localparam logic [btrm_pkg::REFS_W-1:0] REF_ONE = btrm_pkg::REFS_W'(1);

    btrm_pkg::state_t                 state_reg;
    btrm_pkg::state_t                 state_next;

    // latched request
    btrm_pkg::func_t                  func_reg;
    logic [btrm_pkg::DEV_W-1:0]       dev_reg;
    logic [btrm_pkg::BLK_W-1:0]       blk_reg;
    logic [SW-1:0]                    slot_reg;

    // scan bookkeeping
    logic [CW-1:0]                    cnt_reg;
    logic                             rvalid_reg;
    logic [AW-1:0]                    ridx_reg;
    logic                             match_found_reg;
    logic [AW-1:0]                    match_idx_reg;
    btrm_pkg::entry_t                 match_ent_reg;
    logic                             free_found_reg;
    logic [AW-1:0]                    free_idx_reg;
    logic [BKW-1:0]                   free_dist_reg;

    // response register
    logic                             out_valid_reg;
    logic [SW-1:0]                    out_slot_reg;
    logic                             out_hit_reg;
    logic                             out_fill_reg;
    btrm_pkg::status_t                out_status_reg;

    // datapath signals
    logic                             accept;
    logic                             out_free;
    logic                             mod_start;
    logic                             mod_done;
    logic [BKW-1:0]                   home;
    logic                             rd_en;
    logic [AW-1:0]                    rd_addr;
    btrm_pkg::entry_t                 rd_data;
    logic                             wr_en;
    logic [AW-1:0]                    wr_addr;
    btrm_pkg::entry_t                 wr_data;
    logic                             scan_issue;
    logic [AW+SW-1:0]                 slot_wide;
    logic [AW-1:0]                    slot_addr;
    logic                             slot_in_range;
    logic [AW-1:0]                    grant_idx;
    logic [AW+SW-1:0]                 grant_wide;
    logic [BKW:0]                     dist_wide;
    logic [BKW-1:0]                   bucket_gap;
    logic                             is_match;
    logic                             is_better_free;
    logic                             res_load;
    logic                             res_hit;
    logic                             res_fill;
    btrm_pkg::status_t                res_status;
    logic                             res_use_grant;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    // slot index mapped onto the table
    assign slot_wide     = {{AW{1'b0}}, slot_reg};
    assign slot_addr     = slot_wide[AW-1:0];
    assign slot_in_range = slot_wide < SLOT_LIM;

    // response slot carries the low bits of the entry index
    assign grant_wide = {{SW{1'b0}}, grant_idx};

    // bucket distance of the entry being read from the request's bucket
    always_comb
    begin
        if (rd_data.bucket >= home)
        begin
            dist_wide = {1'b0, rd_data.bucket} - {1'b0, home};
        end
        else
        begin
            dist_wide = {1'b0, rd_data.bucket} + BUCKETS_W - {1'b0, home};
        end
    end
    assign bucket_gap = dist_wide[BKW-1:0];

    assign is_match = (rd_data.device == dev_reg) && (rd_data.block == blk_reg);
    assign is_better_free = (rd_data.refs == '0) &&
                            (!free_found_reg || (bucket_gap < free_dist_reg));

    // remainder unit for the request's home bucket
    btrm_mod_unit #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .value     (req.block_number),
        .done      (mod_done),
        .remainder (home)
    );

    // entry table
    btrm_entry_ram #(
        .NUM_BUFFERS (NUM_BUFFERS),
        .AW          (AW)
    ) u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            btrm_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.func == btrm_pkg::FUNC_ACQUIRE)
                    begin
                        state_next = btrm_pkg::S_MOD;
                    end
                    else
                    begin
                        state_next = btrm_pkg::S_SLOT_RD;
                    end
                end
            end
            btrm_pkg::S_MOD:
            begin
                if (mod_done)
                begin
                    state_next = btrm_pkg::S_SCAN;
                end
            end
            btrm_pkg::S_SCAN:
            begin
                if ((cnt_reg == SCAN_END) && !rvalid_reg)
                begin
                    state_next = btrm_pkg::S_COMMIT;
                end
            end
            btrm_pkg::S_COMMIT:
            begin
                if (out_free)
                begin
                    state_next = btrm_pkg::S_IDLE;
                end
            end
            btrm_pkg::S_SLOT_RD:
            begin
                state_next = btrm_pkg::S_SLOT_UPD;
            end
            btrm_pkg::S_SLOT_UPD:
            begin
                if (out_free)
                begin
                    state_next = btrm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = btrm_pkg::S_IDLE;
            end
        endcase
    end

    // sequencer outputs: ram access, table updates and response values
    always_comb
    begin
        req.ready     = (state_reg == btrm_pkg::S_IDLE);
        mod_start     = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = '0;
        scan_issue    = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = rd_data;
        res_load      = 1'b0;
        res_hit       = 1'b0;
        res_fill      = 1'b0;
        res_status    = btrm_pkg::ST_OK;
        res_use_grant = 1'b0;
        grant_idx     = '0;
        unique case (state_reg)
            btrm_pkg::S_IDLE:
            begin
                mod_start = req.valid && (req.func == btrm_pkg::FUNC_ACQUIRE);
            end
            btrm_pkg::S_MOD:
            begin
            end
            btrm_pkg::S_SCAN:
            begin
                if (cnt_reg < SCAN_END)
                begin
                    scan_issue = 1'b1;
                    rd_en      = 1'b1;
                    rd_addr    = cnt_reg[AW-1:0];
                end
            end
            btrm_pkg::S_COMMIT:
            begin
                if (out_free)
                begin
                    res_load      = 1'b1;
                    res_use_grant = 1'b1;
                    if (match_found_reg)
                    begin
                        grant_idx = match_idx_reg;
                        res_hit   = 1'b1;
                        if (match_ent_reg.refs == btrm_pkg::REFS_MAX)
                        begin
                            res_status = btrm_pkg::ST_OVER;
                        end
                        else
                        begin
                            // take a reference on the matching entry
                            res_fill      = !match_ent_reg.valid;
                            wr_en         = 1'b1;
                            wr_addr       = match_idx_reg;
                            wr_data       = match_ent_reg;
                            wr_data.refs  = match_ent_reg.refs + REF_ONE;
                            wr_data.valid = 1'b1;
                        end
                    end
                    else if (free_found_reg)
                    begin
                        // retag the chosen free entry
                        grant_idx      = free_idx_reg;
                        res_fill       = 1'b1;
                        wr_en          = 1'b1;
                        wr_addr        = free_idx_reg;
                        wr_data.device = dev_reg;
                        wr_data.block  = blk_reg;
                        wr_data.refs   = REF_ONE;
                        wr_data.valid  = 1'b1;
                        wr_data.bucket = home;
                    end
                    else
                    begin
                        res_status = btrm_pkg::ST_NOBUF;
                    end
                end
            end
            btrm_pkg::S_SLOT_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = slot_addr;
            end
            btrm_pkg::S_SLOT_UPD:
            begin
                if (out_free)
                begin
                    res_load = 1'b1;
                    wr_addr  = slot_addr;
                    if (slot_in_range)
                    begin
                        if (func_reg == btrm_pkg::FUNC_PIN)
                        begin
                            if (rd_data.refs == btrm_pkg::REFS_MAX)
                            begin
                                res_status = btrm_pkg::ST_OVER;
                            end
                            else
                            begin
                                wr_en        = 1'b1;
                                wr_data.refs = rd_data.refs + REF_ONE;
                            end
                        end
                        else
                        begin
                            if (rd_data.refs == '0)
                            begin
                                res_status = btrm_pkg::ST_UNDER;
                            end
                            else
                            begin
                                wr_en        = 1'b1;
                                wr_data.refs = rd_data.refs - REF_ONE;
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= btrm_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg         <= '0;
            rvalid_reg      <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
        end
        else
        begin
            rvalid_reg <= scan_issue;
            if (accept)
            begin
                cnt_reg         <= '0;
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
            end
            else
            begin
                if (scan_issue)
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
                if (rvalid_reg && is_match && !match_found_reg)
                begin
                    match_found_reg <= 1'b1;
                end
                if (rvalid_reg && is_better_free)
                begin
                    free_found_reg <= 1'b1;
                end
            end
        end
    end

    // scan payload: entry under inspection, first match, nearest free entry
    always_ff @(posedge clk)
    begin
        if (scan_issue)
        begin
            ridx_reg <= cnt_reg[AW-1:0];
        end
        if (rvalid_reg && is_match && !match_found_reg)
        begin
            match_idx_reg <= ridx_reg;
            match_ent_reg <= rd_data;
        end
        if (rvalid_reg && is_better_free)
        begin
            free_idx_reg  <= ridx_reg;
            free_dist_reg <= bucket_gap;
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= req.func;
            dev_reg  <= req.device_number;
            blk_reg  <= req.block_number;
            slot_reg <= req.slot_index;
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_slot_reg   <= res_use_grant ? grant_wide[SW-1:0] : slot_reg;
            out_hit_reg    <= res_hit;
            out_fill_reg   <= res_fill;
            out_status_reg <= res_status;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.granted_slot = out_slot_reg;
    assign rsp.hit          = out_hit_reg;
    assign rsp.needs_fill   = out_fill_reg;
    assign rsp.status       = out_status_reg;

endmodule

`default_nettype wire
